// ===== rtl/id3tfe_pkg.sv =====
// ----------------------------------------------------------------------------
// id3tfe_pkg
// Types and constants shared by the ID3v2 text frame extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package id3tfe_pkg;

    typedef enum logic [2:0] {
        PH_TAGHDR   = 3'd0,
        PH_FRAMEHDR = 3'd1,
        PH_ENCODING = 3'd2,
        PH_MARK     = 3'd3,
        PH_TEXT     = 3'd4,
        PH_SKIP     = 3'd5,
        PH_ENDFLAG  = 3'd6,
        PH_DONE     = 3'd7
    } phase_t;

    localparam logic [2:0] KIND_TITLE   = 3'd0;
    localparam logic [2:0] KIND_ARTIST  = 3'd1;
    localparam logic [2:0] KIND_ALBUM   = 3'd2;
    localparam logic [2:0] KIND_TAG_END = 3'd3;
    localparam logic [2:0] KIND_NO_TAG  = 3'd4;

    localparam logic [23:0] ID_TAG    = 24'h494433;
    localparam logic [31:0] ID_TITLE  = 32'h54495432;
    localparam logic [31:0] ID_ARTIST = 32'h54504531;
    localparam logic [31:0] ID_ALBUM  = 32'h54414C42;

    localparam logic [15:0] BOM_LE = 16'hFFFE;
    localparam logic [15:0] BOM_BE = 16'hFEFF;

    localparam logic [7:0] ENC_LATIN1 = 8'd0;
    localparam logic [7:0] ENC_UTF16  = 8'd1;

    localparam logic [28:0] POS_MAX     = 29'h1FFFFFFF;
    localparam logic [28:0] TAG_HDR_LEN = 29'd10;

    typedef struct packed {
        logic       valid;
        logic [2:0] kind;
    } result_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } held_word_t;

endpackage

`default_nettype wire

// ===== rtl/id3tfe_in_stage.sv =====
// ----------------------------------------------------------------------------
// id3tfe_in_stage
// Input register: holds one accepted word until the walker takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module id3tfe_in_stage (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [7:0]              data_byte,
    input  wire logic                    take,
    output id3tfe_pkg::held_word_t       held
);
    import id3tfe_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;

    assign in_ready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_byte;
        end
    end

    assign held.valid = valid_reg;
    assign held.data  = data_reg;

endmodule

`default_nettype wire

// ===== rtl/id3tfe_walker.sv =====
// ----------------------------------------------------------------------------
// id3tfe_walker
// Tag and frame walk state; one word is processed per step.
// ----------------------------------------------------------------------------
`default_nettype none

module id3tfe_walker (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_wr_en,
    input  wire logic                cfg_wr_data,
    input  wire logic                step,
    input  wire logic [7:0]          data,
    output id3tfe_pkg::result_t      res
);
    import id3tfe_pkg::*;

    phase_t      phase_reg,        phase_next;
    logic [3:0]  header_count_reg, header_count_next;
    logic [63:0] header_shift_reg, header_shift_next;
    logic [27:0] tag_size_reg,     tag_size_next;
    logic [28:0] byte_pos_reg,     byte_pos_next;
    logic [31:0] frame_rem_reg,    frame_rem_next;
    logic [1:0]  field_reg,        field_next;
    logic        wide_reg,         wide_next;
    logic        big_end_reg,      big_end_next;
    logic        parity_reg,       parity_next;
    logic [2:0]  found_reg,        found_next;
    logic        syncsafe_reg;

    logic [28:0] pos_inc;
    logic [63:0] shifted;
    logic [31:0] frame_id;
    logic [31:0] hdr_size;
    logic [31:0] rem_dec;
    logic [15:0] mark;
    logic [1:0]  id_field;

    function automatic logic [27:0] unsync(input logic [31:0] v);
        return {v[30:24], v[22:16], v[14:8], v[6:0]};
    endfunction

    function automatic logic walk_ends(input logic [2:0] ff, input logic [28:0] pos,
                                       input logic [27:0] ts);
        return (ff == 3'b111) || (pos >= ({1'b0, ts} + TAG_HDR_LEN));
    endfunction

    assign pos_inc  = (byte_pos_reg != POS_MAX) ? byte_pos_reg + 29'd1 : byte_pos_reg;
    assign shifted  = {header_shift_reg[55:0], data};
    assign frame_id = header_shift_reg[63:32];
    assign hdr_size = syncsafe_reg ? {4'd0, unsync(header_shift_reg[31:0])}
                                   : header_shift_reg[31:0];
    assign rem_dec  = frame_rem_reg - 32'd1;
    assign mark     = {header_shift_reg[7:0], data};
    assign id_field = (frame_id == ID_TITLE)  ? 2'd0 :
                      (frame_id == ID_ARTIST) ? 2'd1 : 2'd2;

    always_comb
    begin
        phase_next        = phase_reg;
        header_count_next = header_count_reg;
        header_shift_next = header_shift_reg;
        tag_size_next     = tag_size_reg;
        byte_pos_next     = byte_pos_reg;
        frame_rem_next    = frame_rem_reg;
        field_next        = field_reg;
        wide_next         = wide_reg;
        big_end_next      = big_end_reg;
        parity_next       = parity_reg;
        found_next        = found_reg;
        res               = '0;

        if (step)
        begin
            case (phase_reg)
                PH_DONE:
                begin
                end
                PH_ENDFLAG:
                begin
                    res.valid  = 1'b1;
                    res.kind   = KIND_TAG_END;
                    phase_next = PH_DONE;
                end
                PH_TAGHDR:
                begin
                    byte_pos_next     = pos_inc;
                    if (header_count_reg < 4'd3 || header_count_reg >= 4'd6)
                    begin
                        header_shift_next = shifted;
                    end
                    header_count_next = header_count_reg + 4'd1;
                    if (header_count_reg == 4'd9)
                    begin
                        if (header_shift_next[55:32] != ID_TAG)
                        begin
                            res.valid  = 1'b1;
                            res.kind   = KIND_NO_TAG;
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            tag_size_next = unsync(header_shift_next[31:0]);
                            if (walk_ends(found_reg, pos_inc, tag_size_next))
                            begin
                                phase_next = PH_ENDFLAG;
                            end
                            else
                            begin
                                phase_next        = PH_FRAMEHDR;
                                header_count_next = 4'd0;
                            end
                        end
                    end
                end
                PH_FRAMEHDR:
                begin
                    byte_pos_next = pos_inc;
                    if (header_count_reg < 4'd8)
                    begin
                        header_shift_next = shifted;
                    end
                    header_count_next = header_count_reg + 4'd1;
                    if (header_count_reg == 4'd9)
                    begin
                        frame_rem_next = hdr_size;
                        if (frame_id == 32'd0)
                        begin
                            phase_next = PH_ENDFLAG;
                        end
                        else if (frame_id == ID_TITLE || frame_id == ID_ARTIST ||
                                 frame_id == ID_ALBUM)
                        begin
                            field_next = id_field;
                            found_next = found_reg | (3'b001 << id_field);
                            phase_next = PH_ENCODING;
                        end
                        else if (hdr_size == 32'd0)
                        begin
                            if (walk_ends(found_reg, pos_inc, tag_size_reg))
                            begin
                                phase_next = PH_ENDFLAG;
                            end
                            else
                            begin
                                phase_next        = PH_FRAMEHDR;
                                header_count_next = 4'd0;
                            end
                        end
                        else
                        begin
                            phase_next = PH_SKIP;
                        end
                    end
                end
                PH_ENCODING:
                begin
                    byte_pos_next = pos_inc;
                    if (frame_rem_reg != 32'd0)
                    begin
                        frame_rem_next = rem_dec;
                    end
                    parity_next = 1'b0;
                    if (data == ENC_LATIN1)
                    begin
                        wide_next  = 1'b0;
                        phase_next = PH_TEXT;
                    end
                    else if (data == ENC_UTF16)
                    begin
                        wide_next  = 1'b1;
                        phase_next = PH_MARK;
                    end
                    else
                    begin
                        phase_next = PH_SKIP;
                    end
                    if (frame_rem_reg <= 32'd1)
                    begin
                        if (walk_ends(found_reg, pos_inc, tag_size_reg))
                        begin
                            phase_next = PH_ENDFLAG;
                        end
                        else
                        begin
                            phase_next        = PH_FRAMEHDR;
                            header_count_next = 4'd0;
                        end
                    end
                end
                PH_MARK:
                begin
                    byte_pos_next  = pos_inc;
                    frame_rem_next = rem_dec;
                    if (!parity_reg)
                    begin
                        header_shift_next = shifted;
                        parity_next       = 1'b1;
                    end
                    else
                    begin
                        parity_next = 1'b0;
                        if (mark == BOM_LE)
                        begin
                            big_end_next = 1'b0;
                            phase_next   = PH_TEXT;
                        end
                        else if (mark == BOM_BE)
                        begin
                            big_end_next = 1'b1;
                            phase_next   = PH_TEXT;
                        end
                        else
                        begin
                            phase_next = PH_SKIP;
                        end
                    end
                    if (rem_dec == 32'd0)
                    begin
                        if (walk_ends(found_reg, pos_inc, tag_size_reg))
                        begin
                            phase_next = PH_ENDFLAG;
                        end
                        else
                        begin
                            phase_next        = PH_FRAMEHDR;
                            header_count_next = 4'd0;
                        end
                    end
                end
                PH_TEXT:
                begin
                    byte_pos_next  = pos_inc;
                    frame_rem_next = rem_dec;
                    if (!wide_reg || (parity_reg == big_end_reg))
                    begin
                        res.valid = 1'b1;
                        res.kind  = {1'b0, field_reg};
                    end
                    if (wide_reg)
                    begin
                        parity_next = !parity_reg;
                    end
                    if (rem_dec == 32'd0)
                    begin
                        if (walk_ends(found_reg, pos_inc, tag_size_reg))
                        begin
                            phase_next = PH_ENDFLAG;
                        end
                        else
                        begin
                            phase_next        = PH_FRAMEHDR;
                            header_count_next = 4'd0;
                        end
                    end
                end
                PH_SKIP:
                begin
                    byte_pos_next  = pos_inc;
                    frame_rem_next = rem_dec;
                    if (rem_dec == 32'd0)
                    begin
                        if (walk_ends(found_reg, pos_inc, tag_size_reg))
                        begin
                            phase_next = PH_ENDFLAG;
                        end
                        else
                        begin
                            phase_next        = PH_FRAMEHDR;
                            header_count_next = 4'd0;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_TAGHDR;
            header_count_reg <= 4'd0;
            header_shift_reg <= 64'd0;
            tag_size_reg     <= 28'd0;
            byte_pos_reg     <= 29'd0;
            frame_rem_reg    <= 32'd0;
            field_reg        <= 2'd0;
            wide_reg         <= 1'b0;
            big_end_reg      <= 1'b0;
            parity_reg       <= 1'b0;
            found_reg        <= 3'd0;
            syncsafe_reg     <= 1'b1;
        end
        else
        begin
            phase_reg        <= phase_next;
            header_count_reg <= header_count_next;
            header_shift_reg <= header_shift_next;
            tag_size_reg     <= tag_size_next;
            byte_pos_reg     <= byte_pos_next;
            frame_rem_reg    <= frame_rem_next;
            field_reg        <= field_next;
            wide_reg         <= wide_next;
            big_end_reg      <= big_end_next;
            parity_reg       <= parity_next;
            found_reg        <= found_next;
            if (cfg_wr_en)
            begin
                syncsafe_reg <= cfg_wr_data;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/id3v2_text_frame_extractor_unit.sv =====
// An accepted word waits in the input register, then its result (if any) is
// registered in the output register. Throughput: one word per cycle unless a
// result waits at a stalled output; the walker handles each held word in one pass.
// Output register lets a new word in while a result waits to be taken.
// Reset (rst_n low, async): walk restarts at the tag header, no result pending,
// frame sizes read as syncsafe.
// ----------------------------------------------------------------------------
// id3v2_text_frame_extractor_unit
// Streams file bytes, tags title/artist/album characters of an ID3v2 tag.
// ----------------------------------------------------------------------------
`default_nettype none

module id3v2_text_frame_extractor_unit (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] data_byte,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [2:0]      kind,
    input  wire logic       cfg_wr_en,
    input  wire logic       cfg_wr_data
);
    import id3tfe_pkg::*;

    held_word_t held;
    result_t    res;
    logic       advance;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [2:0] kind_reg;

    assign advance = held.valid && (!out_valid_reg || out_ready);

    id3tfe_in_stage u_in (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .take      (advance),
        .held      (held)
    );

    id3tfe_walker u_walk (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .step        (advance),
        .data        (held.data),
        .res         (res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = res.valid;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res.valid)
        begin
            kind_reg <= res.kind;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;

endmodule

`default_nettype wire

// ===== rtl/id3tfe_checker.sv =====
// ----------------------------------------------------------------------------
// id3tfe_checker
// Port-level checks for the ID3v2 text frame extractor, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module id3tfe_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [2:0] kind
);
    import id3tfe_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind))
        else $error("result changed while stalled");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (kind <= KIND_NO_TAG))
        else $error("kind out of range");

    // nothing follows the end or missing-tag word
    a_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && (kind == KIND_TAG_END || kind == KIND_NO_TAG)
        |=> !out_valid)
        else $error("result after walk end");

    // input only stalls behind a pending result
    a_in_open: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with no result pending");

    a_reset: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result pending after reset");

endmodule

bind id3v2_text_frame_extractor_unit id3tfe_checker u_chk (.*);

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for id3v2_text_frame_extractor_unit. One ID3v2 tag is streamed
// in byte by byte: an opening run of frame corner cases (extreme characters,
// both UTF-16 byte orders, odd bodies, bad marks and encodings, empty and
// skipped frames), then random frames, then a walk end picked at random
// (padding, all three fields found, or tag size reached). A byte-level
// model of the walker predicts each result kind; results are checked in order.
// ----------------------------------------------------------------------------

module tb;
    import id3tfe_pkg::*;

    localparam int BYTE_TARGET    = 1700;
    localparam int HOLD_CYCLES    = 250;
    localparam int TAIL_BYTES     = 6;
    localparam int MAX_PRINTS     = 20;

    localparam int END_PADDING    = 0;
    localparam int END_ALL_FIELDS = 1;
    localparam int END_TAG_SIZE   = 2;

    class text_kind_tracker;
        phase_t      phase;
        logic [3:0]  hdr_cnt;
        logic [63:0] shreg;
        logic [27:0] tag_len;
        logic [28:0] pos;
        logic [31:0] remain;
        logic [1:0]  field;
        logic        wide;
        logic        be_text;
        logic        parity;
        logic [2:0]  found;
        logic        syncsafe;
        logic [2:0]  expected_kinds[$];
        int          bytes_in;
        int          errors;
        int          seen[5];

        function new();
            phase    = PH_TAGHDR;
            hdr_cnt  = '0;
            shreg    = '0;
            tag_len  = '0;
            pos      = '0;
            remain   = '0;
            field    = '0;
            wide     = 1'b0;
            be_text  = 1'b0;
            parity   = 1'b0;
            found    = '0;
            syncsafe = 1'b1;
            bytes_in = 0;
            errors   = 0;
            foreach (seen[i]) seen[i] = 0;
        endfunction

        function logic [31:0] seven_bit_size(logic [31:0] v);
            return {4'b0, v[30:24], v[22:16], v[14:8], v[6:0]};
        endfunction

        function bit walk_over();
            return phase == PH_ENDFLAG || phase == PH_DONE;
        endfunction

        function void expect_kind(logic [2:0] k);
            expected_kinds = {expected_kinds, k};
        endfunction

        function void close_frame();
            if (found == 3'b111 || {3'b0, pos} >= {4'b0, tag_len} + 32'd10) begin
                phase = PH_ENDFLAG;
            end else begin
                phase   = PH_FRAMEHDR;
                hdr_cnt = '0;
            end
        endfunction

        function void take_byte(logic [7:0] b);
            logic [31:0] fid;
            logic [31:0] fsize;
            logic [15:0] bom;
            bytes_in++;
            if (phase == PH_DONE)
                return;
            if (phase == PH_ENDFLAG) begin
                expect_kind(KIND_TAG_END);
                phase = PH_DONE;
                return;
            end
            if (pos != POS_MAX)
                pos = pos + 1'b1;
            case (phase)
                PH_TAGHDR: begin
                    if (hdr_cnt < 3 || hdr_cnt >= 6)
                        shreg = {shreg[55:0], b};
                    hdr_cnt = hdr_cnt + 1'b1;
                    if (hdr_cnt >= 10) begin
                        if (shreg[55:32] != ID_TAG) begin
                            expect_kind(KIND_NO_TAG);
                            phase = PH_DONE;
                        end else begin
                            tag_len = 28'(seven_bit_size(shreg[31:0]));
                            close_frame();
                        end
                    end
                end
                PH_FRAMEHDR: begin
                    if (hdr_cnt < 8)
                        shreg = {shreg[55:0], b};
                    hdr_cnt = hdr_cnt + 1'b1;
                    if (hdr_cnt >= 10) begin
                        fid   = shreg[63:32];
                        fsize = shreg[31:0];
                        if (syncsafe)
                            fsize = seven_bit_size(fsize);
                        remain = fsize;
                        if (fid == 32'd0) begin
                            phase = PH_ENDFLAG;
                        end else if (fid == ID_TITLE || fid == ID_ARTIST || fid == ID_ALBUM) begin
                            field = (fid == ID_TITLE) ? 2'd0 : (fid == ID_ARTIST) ? 2'd1 : 2'd2;
                            found = found | (3'b001 << field);
                            phase = PH_ENCODING;
                        end else if (fsize == 32'd0) begin
                            close_frame();
                        end else begin
                            phase = PH_SKIP;
                        end
                    end
                end
                PH_ENCODING: begin
                    if (remain != 32'd0)
                        remain = remain - 1;
                    parity = 1'b0;
                    if (b == ENC_LATIN1) begin
                        wide  = 1'b0;
                        phase = PH_TEXT;
                    end else if (b == ENC_UTF16) begin
                        wide  = 1'b1;
                        phase = PH_MARK;
                    end else begin
                        phase = PH_SKIP;
                    end
                    if (remain == 32'd0)
                        close_frame();
                end
                PH_MARK: begin
                    remain = remain - 1;
                    if (!parity) begin
                        shreg  = {shreg[55:0], b};
                        parity = 1'b1;
                    end else begin
                        bom    = {shreg[7:0], b};
                        parity = 1'b0;
                        if (bom == BOM_LE) begin
                            be_text = 1'b0;
                            phase   = PH_TEXT;
                        end else if (bom == BOM_BE) begin
                            be_text = 1'b1;
                            phase   = PH_TEXT;
                        end else begin
                            phase = PH_SKIP;
                        end
                    end
                    if (remain == 32'd0)
                        close_frame();
                end
                PH_TEXT: begin
                    remain = remain - 1;
                    if (!wide || parity == be_text)
                        expect_kind({1'b0, field});
                    if (wide)
                        parity = ~parity;
                    if (remain == 32'd0)
                        close_frame();
                end
                default: begin
                    remain = remain - 1;
                    if (remain == 32'd0)
                        close_frame();
                end
            endcase
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MAX_PRINTS)
                $display("tb: mismatch at %0t: %s", $realtime, msg);
        endtask

        task check_kind(logic [2:0] got);
            logic [2:0] want;
            if (expected_kinds.size() == 0) begin
                report($sformatf("kind %0d with no result expected", got));
                return;
            end
            want = expected_kinds.pop_front();
            if (got !== want)
                report($sformatf("kind %0d, expected %0d", got, want));
            else
                seen[want]++;
        endtask
    endclass

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       in_valid    = 1'b0;
    logic [7:0] data_byte   = 8'h00;
    logic       out_ready   = 1'b0;
    logic       cfg_wr_en   = 1'b0;
    logic       cfg_wr_data = 1'b0;
    logic       in_ready;
    logic       out_valid;
    logic [2:0] kind;

    text_kind_tracker tracker = new();

    int         send_idle = 33;
    int         recv_idle = 61;
    int         hold_left = 0;
    logic [2:0] withheld;
    logic [2:0] first_field;
    logic [2:0] second_field;
    logic [7:0] body_bytes[$];

    id3v2_text_frame_extractor_unit u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .kind       (kind),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tracker.check_kind(kind);
    end

    function automatic logic [31:0] field_frame_id(logic [2:0] f);
        case (f)
            KIND_TITLE:  return ID_TITLE;
            KIND_ARTIST: return ID_ARTIST;
            default:     return ID_ALBUM;
        endcase
    endfunction

    function automatic void append_byte(input logic [7:0] b);
        body_bytes = {body_bytes, b};
    endfunction

    task automatic send_byte(input logic [7:0] b);
        @(negedge clk);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        tracker.take_byte(b);
    endtask

    task automatic add_random_bytes(input int n);
        for (int i = 0; i < n; i++)
            append_byte(8'($urandom));
    endtask

    // header: id, size (7 bits per byte when syncsafe, spare top bits random), flags
    task automatic send_frame(input logic [31:0] frame_id, input logic [31:0] size);
        logic [3:0]  top_bits;
        logic [31:0] size_field;
        top_bits = 4'($urandom_range(15));
        if (tracker.syncsafe)
            size_field = {top_bits[3], size[27:21], top_bits[2], size[20:14],
                          top_bits[1], size[13:7], top_bits[0], size[6:0]};
        else
            size_field = size;
        for (int i = 3; i >= 0; i--)
            send_byte(frame_id[8*i +: 8]);
        for (int i = 3; i >= 0; i--)
            send_byte(size_field[8*i +: 8]);
        send_byte(8'($urandom));
        send_byte(8'($urandom));
        foreach (body_bytes[i])
            send_byte(body_bytes[i]);
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (tracker.expected_kinds.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_write(input logic v);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        tracker.syncsafe = v;
    endtask

    task automatic send_random_frame();
        int unsigned sel;
        int unsigned len;
        int unsigned pick;
        logic [31:0] fid;
        logic [7:0]  enc;
        bit          empty_text;
        sel  = $urandom_range(99);
        len  = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 12);
        body_bytes.delete();
        if (sel < 70) begin
            fid  = field_frame_id(($urandom_range(1) == 0) ? first_field : second_field);
            pick = $urandom_range(99);
            if (pick < 45)
                enc = ENC_LATIN1;
            else if (pick < 88)
                enc = ENC_UTF16;
            else
                enc = 8'($urandom_range(2, 255));
            append_byte(enc);
            if (enc == ENC_UTF16) begin
                if (pick < 62) begin
                    append_byte(BOM_LE[15:8]);
                    append_byte(BOM_LE[7:0]);
                end else if (pick < 80) begin
                    append_byte(BOM_BE[15:8]);
                    append_byte(BOM_BE[7:0]);
                end else begin
                    add_random_bytes(2);
                end
            end
            add_random_bytes(len);
            empty_text = ($urandom_range(24) == 0);
            if (empty_text) begin
                body_bytes.delete();
                append_byte(enc);
                send_frame(fid, 32'd0);
            end else begin
                send_frame(fid, 32'(body_bytes.size()));
            end
        end else begin
            // near misses of the text ids, or arbitrary ids
            if ($urandom_range(3) == 0) begin
                fid = field_frame_id(3'($urandom_range(2))) ^ (32'd1 << $urandom_range(31));
            end else begin
                fid = $urandom;
                while (fid == 32'd0 || fid == ID_TITLE || fid == ID_ARTIST || fid == ID_ALBUM)
                    fid = $urandom;
            end
            add_random_bytes(len);
            send_frame(fid, 32'(body_bytes.size()));
        end
    endtask

    initial
    begin
        #2_000_000;
        $display("tb: done, errors");
        $finish;
    end

    initial
    begin : receiver
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0) begin
                out_ready <= 1'b0;
                hold_left--;
            end else begin
                out_ready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    initial
    begin : stimulus
        int          end_mode;
        int          stage;
        logic [27:0] tag_len;
        logic [3:0]  top_bits;
        string       end_name;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        cfg_write(1'b0);

        end_mode     = $urandom_range(2);
        withheld     = 3'($urandom_range(2));
        first_field  = 3'((withheld + 1) % 3);
        second_field = 3'((withheld + 2) % 3);
        if (end_mode == END_TAG_SIZE)
            tag_len = 28'(BYTE_TARGET - 40 + $urandom_range(80));
        else if ($urandom_range(1) == 0)
            tag_len = 28'hFFFFFFF;
        else
            tag_len = 28'($urandom_range(28'hFFFFFFF, 28'h100000));

        // tag header
        top_bits = 4'($urandom_range(15));
        send_byte(ID_TAG[23:16]);
        send_byte(ID_TAG[15:8]);
        send_byte(ID_TAG[7:0]);
        send_byte(8'h04);
        send_byte(8'h00);
        send_byte(8'($urandom));
        send_byte({top_bits[3], tag_len[27:21]});
        send_byte({top_bits[2], tag_len[20:14]});
        send_byte({top_bits[1], tag_len[13:7]});
        send_byte({top_bits[0], tag_len[6:0]});

        // corner cases
        body_bytes = '{ENC_LATIN1, 8'h00, 8'hFF, 8'h41};
        send_frame(field_frame_id(first_field), 32'd4);
        body_bytes = '{ENC_UTF16, BOM_LE[15:8], BOM_LE[7:0], 8'h61, 8'h00, 8'h62, 8'h00};
        send_frame(field_frame_id(second_field), 32'd7);
        body_bytes = '{ENC_UTF16, BOM_BE[15:8], BOM_BE[7:0], 8'h00, 8'h63, 8'h80};
        send_frame(field_frame_id(first_field), 32'd6);
        body_bytes = '{ENC_UTF16, BOM_LE[15:8], BOM_LE[7:0], 8'hE9};
        send_frame(field_frame_id(second_field), 32'd4);
        body_bytes = '{ENC_UTF16, 8'hFE, 8'hFE, 8'h01, 8'h02};
        send_frame(field_frame_id(first_field), 32'd5);
        body_bytes = '{8'h02, 8'h41, 8'h42};
        send_frame(field_frame_id(second_field), 32'd3);
        body_bytes = '{8'hFF, 8'h43};
        send_frame(field_frame_id(first_field), 32'd2);
        body_bytes = '{ENC_LATIN1};
        send_frame(field_frame_id(second_field), 32'd0);
        body_bytes = '{ENC_UTF16};
        send_frame(field_frame_id(first_field), 32'd0);
        body_bytes = '{ENC_UTF16, BOM_LE[15:8]};
        send_frame(field_frame_id(first_field), 32'd2);
        body_bytes = '{8'h00, 8'h7F, 8'h80};
        send_frame(32'h54585858, 32'd3);
        body_bytes.delete();
        send_frame(32'h50524956, 32'd0);

        // long output stall while a long text frame keeps coming
        body_bytes.delete();
        append_byte(ENC_LATIN1);
        add_random_bytes(80);
        hold_left = HOLD_CYCLES;
        send_frame(field_frame_id(first_field), 32'(body_bytes.size()));

        stage = 0;
        while ((end_mode == END_TAG_SIZE) ?
               (!tracker.walk_over() && tracker.bytes_in < 4 * BYTE_TARGET) :
               (tracker.bytes_in < BYTE_TARGET))
        begin
            if (stage == 0 && tracker.bytes_in >= BYTE_TARGET / 3) begin
                drain_results();
                cfg_write(1'b1);
                send_idle = 61;
                recv_idle = 33;
                stage     = 1;
            end else if (stage == 1 && tracker.bytes_in >= 2 * BYTE_TARGET / 3) begin
                drain_results();
                cfg_write(1'($urandom_range(1)));
                send_idle = 0;
                recv_idle = 0;
                stage     = 2;
            end
            send_random_frame();
        end

        case (end_mode)
            END_PADDING: begin
                end_name = "padding";
                body_bytes.delete();
                send_frame(32'd0, 32'($urandom_range(255)));
            end
            END_ALL_FIELDS: begin
                end_name = "all three fields found";
                body_bytes.delete();
                append_byte(ENC_LATIN1);
                add_random_bytes(3);
                send_frame(field_frame_id(withheld), 32'd4);
            end
            default: begin
                end_name = "tag size reached";
            end
        endcase

        repeat (TAIL_BYTES) send_byte(8'($urandom));
        drain_results();
        repeat (4) @(posedge clk);

        $display("tb: %0d bytes in; kinds checked: title %0d, artist %0d, album %0d, end %0d",
                 tracker.bytes_in, tracker.seen[KIND_TITLE], tracker.seen[KIND_ARTIST],
                 tracker.seen[KIND_ALBUM], tracker.seen[KIND_TAG_END]);
        $display("tb: walk ended by %s; both frame size formats; one long output stall",
                 end_name);
        if (tracker.errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/id3tfe_pkg.sv
rtl/id3tfe_in_stage.sv
rtl/id3tfe_walker.sv
rtl/id3v2_text_frame_extractor_unit.sv
rtl/id3tfe_checker.sv
tb/tb.sv
